[rtl/aes128_cbc_encrypt_assert.svh]
// Assertion macros for the AES-128 CBC encryptor.
`ifndef AES128_CBC_ENCRYPT_ASSERT_SVH
`define AES128_CBC_ENCRYPT_ASSERT_SVH
// implication checked every clock outside reset
`define ACE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ACE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/ace_pkg.sv]
// Package for the AES-128 CBC encryptor: S-box, xtime, round helpers.
`default_nettype none
package ace_pkg;
   localparam int unsigned Rounds = 10;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // next round constant in GF(2^8)
   function automatic logic [7:0] rcon_next(input logic [7:0] r);
      return xtime(r);
   endfunction

   // one key-schedule step: round key r -> round key r+1
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   typedef struct packed {
      logic start;
      logic busy;
   } ks_ctl_type;
endpackage
`default_nettype wire

[rtl/ace_key_sched.sv]
// Key schedule sequencer: rebuilds the round key store one round key a cycle.
`default_nettype none
module ace_key_sched import ace_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] key,
   input  wire logic [3:0]   rd_index,
   output logic [127:0]      rd_key,
   output ks_ctl_type        ctl
);
   logic [127:0] store [11];
   logic [127:0] cur_ff;
   logic [7:0]   rc_ff;
   logic [3:0]   idx_ff;
   logic         busy_ff;
   logic         pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b1;
         idx_ff  <= '0;
         rc_ff   <= 8'h01;
      end else if (start) begin
         // key register lands at this edge; load it on the next one
         pend_ff <= 1'b1;
      end else if (pend_ff) begin
         pend_ff <= 1'b0;
         busy_ff <= 1'b1;
         idx_ff  <= 4'd0;
         rc_ff   <= 8'h01;
         cur_ff  <= key;
      end else if (busy_ff) begin
         store[idx_ff] <= cur_ff;
         if (idx_ff == 4'(Rounds)) begin
            busy_ff <= 1'b0;
         end else begin
            cur_ff <= key_step(cur_ff, rc_ff);
            rc_ff  <= rcon_next(rc_ff);
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   assign rd_key    = store[rd_index];
   assign ctl.start = start;
   assign ctl.busy  = busy_ff || pend_ff;
endmodule
`default_nettype wire

[rtl/ace_round.sv]
// Shared AES round unit: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`default_nettype none
module ace_round import ace_pkg::*; (
   input  wire logic [127:0] state_in,
   input  wire logic [127:0] round_key,
   input  wire logic         last,
   output logic [127:0]      state_out
);
   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] m [16];

   always_comb begin
      for (int i = 0; i < 16; i++) s[i] = state_in[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, al;
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         m[4*c]   = last ? a0 : a0 ^ al ^ xtime(a0 ^ a1);
         m[4*c+1] = last ? a1 : a1 ^ al ^ xtime(a1 ^ a2);
         m[4*c+2] = last ? a2 : a2 ^ al ^ xtime(a2 ^ a3);
         m[4*c+3] = last ? a3 : a3 ^ al ^ xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++) state_out[127-8*i -: 8] = m[i] ^ round_key[127-8*i -: 8];
   end
endmodule
`default_nettype wire

[rtl/aes128_cbc_encrypt.sv]
// Top level of the AES-128 CBC encryptor.
// One block at a time: a beat is taken, then whitening and ten rounds run
// (the rounds on one shared round unit) at one step per cycle, the last round
// holding while the previous result is still unread; no new beat is taken
// before the block retires. The ciphertext waits in an output register while
// the next beat is taken. After reset and after each key write the round key
// store is rebuilt, and no beat is taken while that runs. Registers:
// key_high 0x00, key_low 0x08, iv_high 0x10, iv_low 0x18, 64-bit data.
`default_nettype none
`include "aes128_cbc_encrypt_assert.svh"
module aes128_cbc_encrypt import ace_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_plain_high,
   input  wire logic [63:0] req_plain_low,
   input  wire logic        req_restart_chain,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_cipher_high,
   output logic [63:0]      rsp_cipher_low,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   typedef enum logic {ST_IDLE, ST_RUN} state_type;
   localparam logic [1:0] RegKeyHi = 2'd0, RegKeyLo = 2'd1, RegIvHi = 2'd2, RegIvLo = 2'd3;

   state_type    state_ff;
   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic [127:0] chain_ff, st_ff, st_in;
   logic         first_ff;
   logic [3:0]   rnd_ff;
   logic [127:0] rk;
   logic         wr, key_wr, take;
   logic         rsp_valid_ff, rsp_valid_in, done;
   ks_ctl_type   ks;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && (paddr[2:0] == 3'd0);
   assign key_wr = wr && (paddr[4:3] == RegKeyHi || paddr[4:3] == RegKeyLo);

   always_comb begin
      case (paddr[4:3])
         RegKeyHi: prdata = key_hi_ff;
         RegKeyLo: prdata = key_lo_ff;
         RegIvHi:  prdata = iv_hi_ff;
         default:  prdata = iv_lo_ff;
      endcase
   end

   ace_key_sched u_ks (
      .clock(clock), .reset(reset), .start(key_wr),
      .key({key_hi_ff, key_lo_ff}), .rd_index(rnd_ff), .rd_key(rk), .ctl(ks)
   );

   ace_round u_rnd (
      .state_in(st_ff), .round_key(rk), .last(rnd_ff == 4'(Rounds)), .state_out(st_in)
   );

   assign req_stall = (state_ff != ST_IDLE) || ks.busy;
   assign take      = req_valid && !req_stall;
   // last round retires only when the output register is free this cycle
   assign done      = (state_ff == ST_RUN) && (rnd_ff == 4'(Rounds)) &&
                      (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cipher_high = chain_ff[127:64];
   assign rsp_cipher_low  = chain_ff[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b1;
         key_hi_ff <= '0; key_lo_ff <= '0; iv_hi_ff <= '0; iv_lo_ff <= '0;
         chain_ff <= '0;
         rnd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (wr) begin
            case (paddr[4:3])
               RegKeyHi: key_hi_ff <= pwdata;
               RegKeyLo: key_lo_ff <= pwdata;
               RegIvHi:  iv_hi_ff  <= pwdata;
               default:  iv_lo_ff  <= pwdata;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  // chaining XOR here; whitening with round key 0 follows at round 0 in ST_RUN
                  st_ff <= {req_plain_high, req_plain_low} ^
                           ((first_ff || req_restart_chain) ? {iv_hi_ff, iv_lo_ff} : chain_ff);
                  rnd_ff   <= 4'd0;
                  first_ff <= 1'b0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (rnd_ff == 4'(Rounds)) begin
                  if (done) begin
                     chain_ff <= st_in;
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  if (rnd_ff == 4'd0) st_ff <= st_ff ^ rk;
                  else st_ff <= st_in;
                  rnd_ff <= rnd_ff + 4'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ACE_ASSERT_IMPL(a_no_take_busy, clock, reset, take, !ks.busy, "beat taken during key build")
   `ACE_ASSERT_NEXT(a_run_after_take, clock, reset, take, state_ff == ST_RUN, "no run after beat")
   `ACE_ASSERT_IMPL(a_rnd_range, clock, reset, state_ff == ST_RUN, rnd_ff <= 4'(Rounds), "round overrun")
   `ACE_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(chain_ff), "result dropped")
endmodule
`default_nettype wire

[verif/aes128_cbc_encrypt_test.sv]
// Testbench for the AES-128 CBC encryptor: self-predicting, random flow control.
`default_nettype none
module aes128_cbc_encrypt_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned SETTLE_CYCLES = 24;

   typedef enum logic [4:0] {
      REG_KEY_HIGH = 5'h00,
      REG_KEY_LOW  = 5'h08,
      REG_IV_HIGH  = 5'h10,
      REG_IV_LOW   = 5'h18
   } csr_addr_e;

   typedef struct {
      bit [63:0] hi;
      bit [63:0] lo;
      bit        restart;
   } plain_beat_t;

   typedef struct {
      bit [63:0] hi;
      bit [63:0] lo;
   } cipher_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic        req_restart_chain = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   aes128_cbc_encrypt dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_plain_high(req_plain_high), .req_plain_low(req_plain_low),
      .req_restart_chain(req_restart_chain),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cipher_high(rsp_cipher_high), .rsp_cipher_low(rsp_cipher_low),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // mirror of the block's state
   bit [7:0]   sbox_tab [256];
   bit [127:0] key_reg, iv_reg, chain_val;
   bit         first_pending;
   bit [127:0] sched [11];

   plain_beat_t  pending_plain [$];
   cipher_beat_t cipher_expected [$];
   plain_beat_t  cur_beat;

   int unsigned mismatches, beats_in, beats_out, restarts, cycles;
   int unsigned burst_left, gap_left, long_hold;
   int unsigned stall_mode, mode_left;

   function automatic bit [7:0] xt(input bit [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic bit [7:0] gf_mul(input bit [7:0] a, input bit [7:0] b);
      bit [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = xt(a);
         b = b >> 1;
      end
      return p;
   endfunction

   // S-box from the field inverse and the affine map
   function automatic void fill_sbox();
      bit [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = 0;
         for (int y = 1; y < 256 && x != 0; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         b = inv;
         sbox_tab[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                       ^ {b[3:0], b[7:4]} ^ 8'h63;
      end
   endfunction

   function automatic void expand_key();
      bit [31:0] w [44];
      bit [31:0] t;
      bit [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = key_reg[127 - 32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sbox_tab[t[31:24]], sbox_tab[t[23:16]], sbox_tab[t[15:8]],
                 sbox_tab[t[7:0]]} ^ {rc, 24'h0};
            rc = xt(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   function automatic bit [127:0] aes_encrypt(input bit [127:0] blk);
      bit [7:0] st [16];
      bit [7:0] t [16];
      bit [7:0] a0, a1, a2, a3, all;
      bit [127:0] res;
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8] ^ sched[0][127 - 8*i -: 8];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[4*c + w] = sbox_tab[st[4*((c + w) % 4) + w]];
         st = t;
         if (r != 10)
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
               st[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
               st[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
               st[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
            end
         for (int i = 0; i < 16; i++) st[i] ^= sched[r][127 - 8*i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
      return res;
   endfunction

   function automatic void predict_cipher(input plain_beat_t p);
      bit [127:0] x, c;
      cipher_beat_t e;
      x = {p.hi, p.lo} ^ ((first_pending || p.restart) ? iv_reg : chain_val);
      c = aes_encrypt(x);
      chain_val = c;
      first_pending = 0;
      e.hi = c[127:64];
      e.lo = c[63:0];
      cipher_expected.push_back(e);
   endfunction

   // sender: bursts and gaps, payload held while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_cipher(cur_beat);
            beats_in++;
            if (cur_beat.restart) restarts++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_plain.size() > 0) begin
               cur_beat = pending_plain.pop_front();
               req_plain_high <= cur_beat.hi;
               req_plain_low <= cur_beat.lo;
               req_restart_chain <= cur_beat.restart;
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: a long hold on request, else a pattern that changes now and then
   always @(posedge clock) begin
      if (!reset) begin
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(50, 400);
            end else mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 80);
               default: rsp_stall <= (cycles % 7 < 3);
            endcase
         end
      end
   end

   // result check
   always @(posedge clock) begin
      cipher_beat_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (cipher_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected cipher beat %h_%h", rsp_cipher_high, rsp_cipher_low);
         end else begin
            e = cipher_expected.pop_front();
            if (rsp_cipher_high !== e.hi || rsp_cipher_low !== e.lo) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cipher mismatch: expected %h_%h got %h_%h",
                           e.hi, e.lo, rsp_cipher_high, rsp_cipher_low);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycles, cipher_expected.size());
         $display("aes128_cbc_encrypt_test: errors");
         $finish;
      end
   end

   task automatic csr_write(input csr_addr_e a, input bit [63:0] d);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= a;
      pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (a)
         REG_KEY_HIGH: begin key_reg[127:64] = d; expand_key(); end
         REG_KEY_LOW:  begin key_reg[63:0] = d; expand_key(); end
         REG_IV_HIGH:  iv_reg[127:64] = d;
         default:      iv_reg[63:0] = d;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_plain.size() > 0 || req_valid || cipher_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_beat(input bit [63:0] hi, input bit [63:0] lo, input bit rs);
      plain_beat_t p;
      p.hi = hi;
      p.lo = lo;
      p.restart = rs;
      pending_plain.push_back(p);
   endtask

   function automatic bit [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_phase(input int unsigned n, input int unsigned restart_pct);
      for (int i = 0; i < n; i++)
         queue_beat(rand64(), rand64(), $urandom_range(0, 99) < restart_pct);
   endtask

   initial begin
      fill_sbox();
      key_reg = '0;
      iv_reg = '0;
      chain_val = '0;
      first_pending = 1;
      expand_key();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset state: all-zero key and IV; first beat chains from the IV
      queue_beat('0, '0, 1'b0);
      queue_beat('1, '1, 1'b0);
      queue_beat('0, '0, 1'b1);
      queue_beat('1, '1, 1'b1);
      wait_drained();

      // FIPS-197 example key and block
      csr_write(REG_KEY_HIGH, 64'h0001020304050607);
      csr_write(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
      queue_beat(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      queue_beat(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      queue_beat(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
      for (int i = 0; i < 8; i++)
         queue_beat(64'h1 << (i * 9), 64'h8000000000000000 >> (i * 7), i[0]);
      wait_drained();

      // IV change mid-stream: only restart beats pick it up
      csr_write(REG_IV_HIGH, '1);
      csr_write(REG_IV_LOW, '1);
      queue_beat(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      queue_beat(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
      queue_beat('0, '1, 1'b0);
      wait_drained();

      // key change keeps the chain
      csr_write(REG_KEY_HIGH, '1);
      csr_write(REG_KEY_LOW, '1);
      queue_beat('1, '0, 1'b0);
      queue_beat('0, '0, 1'b0);
      wait_drained();

      // random settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(REG_KEY_HIGH, '0); csr_write(REG_KEY_LOW, '0); end
            1: begin csr_write(REG_IV_HIGH, '0); csr_write(REG_IV_LOW, '0); end
            default: begin
               csr_write(REG_KEY_HIGH, rand64());
               csr_write(REG_KEY_LOW, rand64());
               csr_write(REG_IV_HIGH, rand64());
               csr_write(REG_IV_LOW, rand64());
            end
         endcase
         random_phase(260, (ph == 3) ? 60 : 15);
         // receiver goes quiet while the sender keeps offering
         if (ph == 2) long_hold = 400;
         wait_drained();
      end

      $display("%0d plaintext beats (%0d with chain restart), %0d cipher beats checked",
               beats_in, restarts, beats_out);
      $display("key and IV rewritten across zero, all-ones and random values, %0d cycles",
               cycles);
      if (mismatches == 0) $display("aes128_cbc_encrypt_test: clean");
      else $display("aes128_cbc_encrypt_test: errors");
      $finish;
   end
endmodule
`default_nettype wire
